FILE: hw/rtl/dac_pkg.sv
`timescale 1ns / 1ps

package dac_pkg;

  localparam int MEMORY_WORDS = 100;
  localparam int WORD_LO = -9999;
  localparam int WORD_HI = 9999;

  localparam int DataW = 16;
  localparam int WordW = 15;
  localparam int MagW  = 14;
  localparam int CntW  = 7;
  localparam int OpW   = 8;
  localparam int StatW = 3;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK          = 3'd0,
    ST_HALTED      = 3'd1,
    ST_OVERFLOW    = 3'd2,
    ST_DIV_ZERO    = 3'd3,
    ST_BAD_OPCODE  = 3'd4,
    ST_REJECTED    = 3'd5,
    ST_BEYOND      = 3'd6,
    ST_NOT_RUNNING = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    RUN_RUNNING = 2'd0,
    RUN_HALTED  = 2'd1,
    RUN_FAULTED = 2'd2
  } run_e;

  localparam logic signed [OpW-1:0] OP_READ     = 8'sd10;
  localparam logic signed [OpW-1:0] OP_WRITE    = 8'sd11;
  localparam logic signed [OpW-1:0] OP_LOAD     = 8'sd20;
  localparam logic signed [OpW-1:0] OP_STORE    = 8'sd21;
  localparam logic signed [OpW-1:0] OP_ADD      = 8'sd30;
  localparam logic signed [OpW-1:0] OP_SUBTRACT = 8'sd31;
  localparam logic signed [OpW-1:0] OP_DIVIDE   = 8'sd32;
  localparam logic signed [OpW-1:0] OP_MULTIPLY = 8'sd33;
  localparam logic signed [OpW-1:0] OP_BRANCH   = 8'sd40;
  localparam logic signed [OpW-1:0] OP_BRANCHNEG  = 8'sd41;
  localparam logic signed [OpW-1:0] OP_BRANCHZERO = 8'sd42;
  localparam logic signed [OpW-1:0] OP_HALT     = 8'sd43;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FETCH,
    S_SPLIT1,
    S_SPLIT2,
    S_OPERAND,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_DIVFIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic dispatch;
    logic rd_fetch;
    logic fetch;
    logic split1;
    logic split2;
    logic rd_opnd;
    logic exec;
    logic div_step;
    logic div_fin;
    logic mul_fin;
    logic ld_out;
  } dac_cmd_t;

  typedef struct packed {
    logic step_go;
    logic mul_go;
    logic div_go;
    logic div_last;
  } dac_stat_t;

endpackage

FILE: hw/rtl/decimal_accumulator_cpu.sv
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid_i/in_ready_o  cmd_i, data_value_i
// out      out_valid_o/out_ready_i status_o, write_*_o, accumulator_value_o,
//                                 counter_value_o, instruction_word_o, opcode_o,
//                                 operand_address_o, read_used_o
//
// One item at a time. Load, restart, rejected items and steps that fetch nothing go from
// dispatch straight to the result; an executed instruction passes fetch, a split by 100
// (SPLIT1, SPLIT2), operand read and execute (two memory reads), multiply finishes in S_MUL
// and divide runs a 14-step restoring divider; a zero divisor skips the divider.
// Reset clears the accumulator, counters, run state and the memory valid bits.
// A new item transfers while the previous result waits; the next result holds
// in the controller until the output register is taken.

module decimal_accumulator_cpu #(
  parameter int MemWords = dac_pkg::MEMORY_WORDS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [dac_pkg::DataW-1:0]  data_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dac_pkg::StatW-1:0]         status_o,
  output logic                              write_valid_o,
  output logic [dac_pkg::CntW-1:0]          write_address_o,
  output logic signed [dac_pkg::WordW-1:0]  write_value_o,
  output logic signed [dac_pkg::WordW-1:0]  accumulator_value_o,
  output logic [dac_pkg::CntW-1:0]          counter_value_o,
  output logic signed [dac_pkg::WordW-1:0]  instruction_word_o,
  output logic signed [dac_pkg::OpW-1:0]    opcode_o,
  output logic signed [dac_pkg::OpW-1:0]    operand_address_o,
  output logic                              read_used_o
);
  import dac_pkg::*;

  dac_cmd_t  cmd;
  dac_stat_t stat;

  dac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dac_dp #(
    .MemWords (MemWords)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cmd_in_i            (cmd_i),
    .data_i              (data_value_i),
    .status_o            (status_o),
    .write_valid_o       (write_valid_o),
    .write_address_o     (write_address_o),
    .write_value_o       (write_value_o),
    .accumulator_value_o (accumulator_value_o),
    .counter_value_o     (counter_value_o),
    .instruction_word_o  (instruction_word_o),
    .opcode_o            (opcode_o),
    .operand_address_o   (operand_address_o),
    .read_used_o         (read_used_o)
  );

endmodule

FILE: hw/rtl/dac_ctrl.sv
`timescale 1ns / 1ps

module dac_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  dac_pkg::dac_stat_t stat_i,
  output dac_pkg::dac_cmd_t  cmd_o
);
  import dac_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.step_go) begin
          cmd_o.rd_fetch = 1'b1;
          state_d        = S_FETCH;
        end else begin
          cmd_o.dispatch = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_SPLIT1;
      end
      S_SPLIT1: begin
        cmd_o.split1 = 1'b1;
        state_d      = S_SPLIT2;
      end
      S_SPLIT2: begin
        cmd_o.split2 = 1'b1;
        state_d      = S_OPERAND;
      end
      S_OPERAND: begin
        cmd_o.rd_opnd = 1'b1;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.mul_go) begin
          state_d = S_MUL;
        end else if (stat_i.div_go) begin
          state_d = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MUL: begin
        cmd_o.mul_fin = 1'b1;
        state_d       = S_DONE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_DIVFIN;
        end
      end
      S_DIVFIN: begin
        cmd_o.div_fin = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/dac_dp.sv
`timescale 1ns / 1ps

module dac_dp #(
  parameter int MemWords = dac_pkg::MEMORY_WORDS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dac_pkg::dac_cmd_t                 cmd_i,
  output dac_pkg::dac_stat_t                stat_o,
  input  logic [1:0]                        cmd_in_i,
  input  logic signed [dac_pkg::DataW-1:0]  data_i,
  output logic [dac_pkg::StatW-1:0]         status_o,
  output logic                              write_valid_o,
  output logic [dac_pkg::CntW-1:0]          write_address_o,
  output logic signed [dac_pkg::WordW-1:0]  write_value_o,
  output logic signed [dac_pkg::WordW-1:0]  accumulator_value_o,
  output logic [dac_pkg::CntW-1:0]          counter_value_o,
  output logic signed [dac_pkg::WordW-1:0]  instruction_word_o,
  output logic signed [dac_pkg::OpW-1:0]    opcode_o,
  output logic signed [dac_pkg::OpW-1:0]    operand_address_o,
  output logic                              read_used_o
);
  import dac_pkg::*;

  localparam int AddrW    = $clog2(MemWords);
  localparam int ProdW    = 27;
  localparam int RecipSh  = 19;
  localparam int DivCntW  = $clog2(MagW);
  localparam int MulW     = 2 * WordW;

  localparam logic [12:0] Recip100 = 13'd5243;
  localparam logic [MagW-1:0] Hundred = 14'd100;
  localparam logic [CntW-1:0] MemTop = CntW'(MemWords);

  localparam logic signed [DataW-1:0] DataMin = DataW'(WORD_LO);
  localparam logic signed [DataW-1:0] DataMax = DataW'(WORD_HI);
  localparam logic signed [MulW-1:0]  MulMin  = MulW'(WORD_LO);
  localparam logic signed [MulW-1:0]  MulMax  = MulW'(WORD_HI);

  // Word memory with per-entry valid bits; an unwritten entry reads as zero.
  logic [WordW-1:0] mem [MemWords];
  logic [MemWords-1:0] vld_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_wa;
  logic [WordW-1:0] mem_wd;
  logic             rd_en;
  logic [AddrW-1:0] rd_a;
  logic [WordW-1:0] rdata_q;
  logic             rvld_q;

  logic [1:0]              cmd_q, cmd_d;
  logic signed [DataW-1:0] data_q, data_d;
  logic signed [WordW-1:0] acc_q, acc_d;
  logic [CntW-1:0]         ic_q, ic_d;
  logic [CntW-1:0]         lp_q, lp_d;
  run_e                    run_q, run_d;

  logic signed [WordW-1:0] word_q, word_d;
  logic [ProdW-1:0]        prod_q, prod_d;
  logic signed [OpW-1:0]   opc_q, opc_d;
  logic signed [OpW-1:0]   adr_q, adr_d;
  status_e                 st_q, st_d;
  logic                    wv_q, wv_d;
  logic signed [WordW-1:0] wval_q, wval_d;
  logic                    ru_q, ru_d;

  logic signed [MulW-1:0]  mul_q, mul_d;
  logic [MagW-1:0]         dvs_q, dvs_d;
  logic [MagW-1:0]         dquo_q, dquo_d;
  logic [MagW-1:0]         drem_q, drem_d;
  logic [DivCntW-1:0]      dcnt_q, dcnt_d;
  logic                    dneg_q, dneg_d;

  logic signed [WordW-1:0] mv;
  logic signed [WordW-1:0] mv_neg, acc_neg, word_neg;
  logic [MagW-1:0]         mv_mag, acc_mag, w_mag;
  logic signed [DataW-1:0] acc_x, mv_x, sum, diff;
  logic                    data_ok;
  logic [6:0]              qm;
  logic [MagW-1:0]         rm_full;
  logic [MagW:0]           div_shl;
  logic [MagW+1:0]         div_diff;
  logic                    div_ge;
  logic signed [WordW-1:0] div_res;

  assign mv       = rvld_q ? $signed(rdata_q) : '0;
  assign mv_neg   = -mv;
  assign acc_neg  = -acc_q;
  assign word_neg = -word_q;
  assign mv_mag   = mv[WordW-1] ? mv_neg[MagW-1:0] : mv[MagW-1:0];
  assign acc_mag  = acc_q[WordW-1] ? acc_neg[MagW-1:0] : acc_q[MagW-1:0];
  assign w_mag    = word_q[WordW-1] ? word_neg[MagW-1:0] : word_q[MagW-1:0];
  assign acc_x    = DataW'(acc_q);
  assign mv_x     = DataW'(mv);
  assign sum      = acc_x + mv_x;
  assign diff     = acc_x - mv_x;
  assign data_ok  = (data_q >= DataMin) && (data_q <= DataMax);

  // opcode and operand: multiply by a scaled reciprocal of 100, then fix up
  assign qm      = prod_q[RecipSh+6:RecipSh];
  assign rm_full = w_mag - MagW'(qm) * Hundred;

  assign div_shl  = {drem_q, dquo_q[MagW-1]};
  assign div_diff = {1'b0, div_shl} - {2'b00, dvs_q};
  assign div_ge   = ~div_diff[MagW+1];
  assign div_res  = dneg_q ? -$signed({1'b0, dquo_q}) : $signed({1'b0, dquo_q});

  assign stat_o.step_go  = (cmd_q == CMD_STEP) && (run_q == RUN_RUNNING) && (ic_q < MemTop);
  assign stat_o.mul_go   = !adr_q[OpW-1] && (opc_q == OP_MULTIPLY);
  assign stat_o.div_go   = !adr_q[OpW-1] && (opc_q == OP_DIVIDE) && (mv != '0);
  assign stat_o.div_last = (dcnt_q == '0);

  assign rd_en = cmd_i.rd_fetch | (cmd_i.rd_opnd & ~adr_q[OpW-1]);
  assign rd_a  = cmd_i.rd_fetch ? ic_q[AddrW-1:0] : adr_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
      acc_q  <= '0;
      ic_q   <= '0;
      lp_q   <= '0;
      run_q  <= RUN_RUNNING;
    end else begin
      if (mem_we) begin
        vld_q[mem_wa] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= vld_q[rd_a];
      end
      acc_q <= acc_d;
      ic_q  <= ic_d;
      lp_q  <= lp_d;
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    data_q <= data_d;
    word_q <= word_d;
    prod_q <= prod_d;
    opc_q  <= opc_d;
    adr_q  <= adr_d;
    st_q   <= st_d;
    wv_q   <= wv_d;
    wval_q <= wval_d;
    ru_q   <= ru_d;
    mul_q  <= mul_d;
    dvs_q  <= dvs_d;
    dquo_q <= dquo_d;
    drem_q <= drem_d;
    dcnt_q <= dcnt_d;
    dneg_q <= dneg_d;
  end

  always_comb begin
    cmd_d  = cmd_q;
    data_d = data_q;
    acc_d  = acc_q;
    ic_d   = ic_q;
    lp_d   = lp_q;
    run_d  = run_q;
    word_d = word_q;
    prod_d = prod_q;
    opc_d  = opc_q;
    adr_d  = adr_q;
    st_d   = st_q;
    wv_d   = wv_q;
    wval_d = wval_q;
    ru_d   = ru_q;
    mul_d  = mul_q;
    dvs_d  = dvs_q;
    dquo_d = dquo_q;
    drem_d = drem_q;
    dcnt_d = dcnt_q;
    dneg_d = dneg_q;
    mem_we = 1'b0;
    mem_wa = lp_q[AddrW-1:0];
    mem_wd = data_q[WordW-1:0];

    if (cmd_i.capture) begin
      cmd_d  = cmd_in_i;
      data_d = data_i;
      word_d = '0;
      opc_d  = '0;
      adr_d  = '0;
      st_d   = ST_OK;
      wv_d   = 1'b0;
      wval_d = '0;
      ru_d   = 1'b0;
    end

    if (cmd_i.dispatch) begin
      case (cmd_q)
        CMD_LOAD: begin
          if (!data_ok) begin
            st_d = ST_REJECTED;
          end else if (lp_q >= MemTop) begin
            st_d = ST_BEYOND;
          end else begin
            mem_we = 1'b1;
            lp_d   = lp_q + 1'b1;
          end
        end
        CMD_STEP: begin
          // only steps that cannot fetch get here
          if (run_q != RUN_RUNNING) begin
            st_d = ST_NOT_RUNNING;
          end else begin
            st_d  = ST_BEYOND;
            run_d = RUN_FAULTED;
          end
        end
        CMD_RESTART: begin
          acc_d = '0;
          ic_d  = '0;
          lp_d  = '0;
          run_d = RUN_RUNNING;
        end
        default: begin
          st_d = ST_REJECTED;
        end
      endcase
    end

    if (cmd_i.fetch) begin
      word_d = mv;
    end

    if (cmd_i.split1) begin
      prod_d = ProdW'(w_mag) * ProdW'(Recip100);
    end

    if (cmd_i.split2) begin
      opc_d = word_q[WordW-1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
      adr_d = word_q[WordW-1] ? -$signed({1'b0, rm_full[6:0]})
                              : $signed({1'b0, rm_full[6:0]});
    end

    if (cmd_i.exec) begin
      if (adr_q[OpW-1]) begin
        st_d  = ST_BAD_OPCODE;
        run_d = RUN_FAULTED;
      end else begin
        case (opc_q)
          OP_READ: begin
            if (!data_ok) begin
              st_d = ST_REJECTED;
            end else begin
              mem_we = 1'b1;
              mem_wa = adr_q[AddrW-1:0];
              ru_d   = 1'b1;
              ic_d   = ic_q + 1'b1;
            end
          end
          OP_WRITE: begin
            wv_d   = 1'b1;
            wval_d = mv;
            ic_d   = ic_q + 1'b1;
          end
          OP_LOAD: begin
            acc_d = mv;
            ic_d  = ic_q + 1'b1;
          end
          OP_STORE: begin
            mem_we = 1'b1;
            mem_wa = adr_q[AddrW-1:0];
            mem_wd = acc_q;
            ic_d   = ic_q + 1'b1;
          end
          OP_ADD: begin
            if ((sum < DataMin) || (sum > DataMax)) begin
              st_d  = ST_OVERFLOW;
              run_d = RUN_FAULTED;
            end else begin
              acc_d = sum[WordW-1:0];
              ic_d  = ic_q + 1'b1;
            end
          end
          OP_SUBTRACT: begin
            if ((diff < DataMin) || (diff > DataMax)) begin
              st_d  = ST_OVERFLOW;
              run_d = RUN_FAULTED;
            end else begin
              acc_d = diff[WordW-1:0];
              ic_d  = ic_q + 1'b1;
            end
          end
          OP_DIVIDE: begin
            if (mv == '0) begin
              st_d  = ST_DIV_ZERO;
              run_d = RUN_FAULTED;
            end else begin
              dvs_d  = mv_mag;
              dquo_d = acc_mag;
              drem_d = '0;
              dcnt_d = DivCntW'(MagW - 1);
              dneg_d = acc_q[WordW-1] ^ mv[WordW-1];
            end
          end
          OP_MULTIPLY: begin
            mul_d = MulW'(acc_q) * MulW'(mv);
          end
          OP_BRANCH: begin
            ic_d = adr_q[CntW-1:0];
          end
          OP_BRANCHNEG: begin
            ic_d = (acc_q < 0) ? adr_q[CntW-1:0] : ic_q + 1'b1;
          end
          OP_BRANCHZERO: begin
            ic_d = (acc_q == '0) ? adr_q[CntW-1:0] : ic_q + 1'b1;
          end
          OP_HALT: begin
            st_d  = ST_HALTED;
            run_d = RUN_HALTED;
          end
          default: begin
            st_d  = ST_BAD_OPCODE;
            run_d = RUN_FAULTED;
          end
        endcase
      end
    end

    // restoring divide on magnitudes, one quotient bit per cycle
    if (cmd_i.div_step) begin
      drem_d = div_ge ? div_diff[MagW-1:0] : div_shl[MagW-1:0];
      dquo_d = {dquo_q[MagW-2:0], div_ge};
      dcnt_d = dcnt_q - 1'b1;
    end

    if (cmd_i.div_fin) begin
      acc_d = div_res;
      ic_d  = ic_q + 1'b1;
    end

    if (cmd_i.mul_fin) begin
      if ((mul_q < MulMin) || (mul_q > MulMax)) begin
        st_d  = ST_OVERFLOW;
        run_d = RUN_FAULTED;
      end else begin
        acc_d = mul_q[WordW-1:0];
        ic_d  = ic_q + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_out) begin
      status_o            <= st_q;
      write_valid_o       <= wv_q;
      write_address_o     <= wv_q ? adr_q[CntW-1:0] : '0;
      write_value_o       <= wval_q;
      accumulator_value_o <= acc_q;
      counter_value_o     <= ic_q;
      instruction_word_o  <= word_q;
      opcode_o            <= opc_q;
      operand_address_o   <= adr_q;
      read_used_o         <= ru_q;
    end
  end

endmodule
